@@ sv/vaor_pkg.sv @@
// ----------------------------------------------------------------------------
// vaor_pkg
// Shared constants, command codes, step addresses and control/status types
// for the voice allocator with oldest key-off release.
// ----------------------------------------------------------------------------
package vaor_pkg;

  localparam int VOICES  = 16;
  localparam int VW      = $clog2(VOICES);
  localparam int CW      = $clog2(VOICES + 1);
  localparam int CMD_W   = 3;
  localparam int VOICE_W = 4;
  localparam int STEP_W  = 4;

  // command codes
  localparam logic [CMD_W-1:0] CMD_ALLOC      = 3'd0;
  localparam logic [CMD_W-1:0] CMD_REL_OLDEST = 3'd1;
  localparam logic [CMD_W-1:0] CMD_REL_VOICE  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_KEY_ON     = 3'd3;
  localparam logic [CMD_W-1:0] CMD_KEY_OFF    = 3'd4;

  // microprogram step addresses
  localparam logic [STEP_W-1:0] S_IDLE = 4'd0;
  localparam logic [STEP_W-1:0] S_AL0  = 4'd1;
  localparam logic [STEP_W-1:0] S_AL1  = 4'd2;
  localparam logic [STEP_W-1:0] S_RV0  = 4'd3;
  localparam logic [STEP_W-1:0] S_RO0  = 4'd4;
  localparam logic [STEP_W-1:0] S_WALK = 4'd5;
  localparam logic [STEP_W-1:0] S_FR0  = 4'd6;
  localparam logic [STEP_W-1:0] S_FR1  = 4'd7;
  localparam logic [STEP_W-1:0] S_NF0  = 4'd8;
  localparam logic [STEP_W-1:0] S_NF1  = 4'd9;
  localparam logic [STEP_W-1:0] S_KEY  = 4'd10;
  localparam logic [STEP_W-1:0] S_FIN  = 4'd11;
  localparam logic [STEP_W-1:0] S_ERR  = 4'd12;

  typedef enum logic [3:0] {
    A_NONE      = 4'd0,
    A_LATCH     = 4'd1,
    A_ALLOC     = 4'd2,
    A_WALK_INIT = 4'd3,
    A_WALK      = 4'd4,
    A_UNLINK    = 4'd5,
    A_APPEND    = 4'd6,
    A_PICK_HEAD = 4'd7,
    A_KEY       = 4'd8,
    A_ERR       = 4'd9,
    A_FINISH    = 4'd10
  } act_e;

  typedef enum logic [1:0] {
    R_NONE      = 2'd0,
    R_FREE_HEAD = 2'd1,
    R_BUSY_HEAD = 2'd2,
    R_RD        = 2'd3
  } rsel_e;

  typedef enum logic [2:0] {
    J_NEXT     = 3'd0,
    J_GOTO     = 3'd1,
    J_IF       = 3'd2,
    J_WAIT     = 3'd3,
    J_WALK     = 3'd4,
    J_DISPATCH = 3'd5
  } jmp_e;

  typedef enum logic [2:0] {
    C_NONE       = 3'd0,
    C_FREE_EMPTY = 3'd1,
    C_BUSY_EMPTY = 3'd2,
    C_NOT_OCC    = 3'd3,
    C_REL_VOICE  = 3'd4,
    C_V_BAD      = 3'd5,
    C_OUT_FREE   = 3'd6
  } cond_e;

  typedef struct packed {
    act_e              act;
    rsel_e             rsel;
    jmp_e              jmp;
    cond_e             cond;
    logic [STEP_W-1:0] target;
  } ctrl_t;

  typedef struct packed {
    logic free_empty;
    logic busy_empty;
    logic not_occ;
    logic rel_voice;
    logic v_bad;
    logic out_free;
    logic walk_done;
    logic walk_match;
  } stat_t;

endpackage

@@ sv/vaor_cmd_if.sv @@
// ----------------------------------------------------------------------------
// vaor_cmd_if
// Request channel: command and voice number with valid/ready handshake.
// ----------------------------------------------------------------------------
interface vaor_cmd_if;
  logic                            valid;
  logic                            ready;
  logic [vaor_pkg::CMD_W-1:0]      command;
  logic [vaor_pkg::VOICE_W-1:0]    voice;

  modport source (output valid, command, voice, input ready);
  modport sink   (input valid, command, voice, output ready);
endinterface

@@ sv/vaor_res_if.sv @@
// ----------------------------------------------------------------------------
// vaor_res_if
// Result channel: voice, error flag and free-voice flag with valid/ready.
// ----------------------------------------------------------------------------
interface vaor_res_if;
  logic                            valid;
  logic                            ready;
  logic [vaor_pkg::VOICE_W-1:0]    voice_out;
  logic                            error;
  logic                            free_available;

  modport source (output valid, voice_out, error, free_available, input ready);
  modport sink   (input valid, voice_out, error, free_available, output ready);
endinterface

@@ sv/vaor_seq.sv @@
// ----------------------------------------------------------------------------
// vaor_seq
// Step counter and microprogram ROM. Each step issues one control word to the
// datapath and picks the next step from datapath status.
// ----------------------------------------------------------------------------
module vaor_seq (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          accept_i,
  input  logic [vaor_pkg::CMD_W-1:0]    command_i,
  input  vaor_pkg::stat_t               stat_i,
  output vaor_pkg::ctrl_t               ctrl_o,
  output logic                          idle_o
);

  logic [vaor_pkg::STEP_W-1:0] pc_q, pc_d;
  vaor_pkg::ctrl_t             cw;
  logic                        cond;

  function automatic vaor_pkg::ctrl_t ucode(input logic [vaor_pkg::STEP_W-1:0] pc);
    vaor_pkg::ctrl_t c;
    c = '{act: vaor_pkg::A_NONE, rsel: vaor_pkg::R_NONE, jmp: vaor_pkg::J_GOTO,
          cond: vaor_pkg::C_NONE, target: vaor_pkg::S_IDLE};
    unique case (pc)
      vaor_pkg::S_IDLE: begin
        c.act = vaor_pkg::A_LATCH;
        c.jmp = vaor_pkg::J_DISPATCH;
      end
      vaor_pkg::S_AL0: begin
        c.rsel   = vaor_pkg::R_FREE_HEAD;
        c.jmp    = vaor_pkg::J_IF;
        c.cond   = vaor_pkg::C_FREE_EMPTY;
        c.target = vaor_pkg::S_ERR;
      end
      vaor_pkg::S_AL1: begin
        c.act    = vaor_pkg::A_ALLOC;
        c.target = vaor_pkg::S_FIN;
      end
      vaor_pkg::S_RV0: begin
        c.jmp    = vaor_pkg::J_IF;
        c.cond   = vaor_pkg::C_NOT_OCC;
        c.target = vaor_pkg::S_ERR;
      end
      vaor_pkg::S_RO0: begin
        c.act    = vaor_pkg::A_WALK_INIT;
        c.rsel   = vaor_pkg::R_BUSY_HEAD;
        c.jmp    = vaor_pkg::J_IF;
        c.cond   = vaor_pkg::C_BUSY_EMPTY;
        c.target = vaor_pkg::S_ERR;
      end
      vaor_pkg::S_WALK: begin
        c.act    = vaor_pkg::A_WALK;
        c.rsel   = vaor_pkg::R_RD;
        c.jmp    = vaor_pkg::J_WALK;
        c.target = vaor_pkg::S_NF0;
      end
      vaor_pkg::S_FR0: begin
        c.act = vaor_pkg::A_UNLINK;
        c.jmp = vaor_pkg::J_NEXT;
      end
      vaor_pkg::S_FR1: begin
        c.act    = vaor_pkg::A_APPEND;
        c.target = vaor_pkg::S_FIN;
      end
      vaor_pkg::S_NF0: begin
        c.act    = vaor_pkg::A_PICK_HEAD;
        c.rsel   = vaor_pkg::R_BUSY_HEAD;
        c.jmp    = vaor_pkg::J_IF;
        c.cond   = vaor_pkg::C_REL_VOICE;
        c.target = vaor_pkg::S_ERR;
      end
      vaor_pkg::S_NF1: begin
        c.target = vaor_pkg::S_FR0;
      end
      vaor_pkg::S_KEY: begin
        c.act    = vaor_pkg::A_KEY;
        c.jmp    = vaor_pkg::J_IF;
        c.cond   = vaor_pkg::C_V_BAD;
        c.target = vaor_pkg::S_ERR;
      end
      vaor_pkg::S_FIN: begin
        c.act    = vaor_pkg::A_FINISH;
        c.jmp    = vaor_pkg::J_WAIT;
        c.cond   = vaor_pkg::C_OUT_FREE;
        c.target = vaor_pkg::S_IDLE;
      end
      vaor_pkg::S_ERR: begin
        c.act    = vaor_pkg::A_ERR;
        c.target = vaor_pkg::S_FIN;
      end
      default: begin
        c.target = vaor_pkg::S_IDLE;
      end
    endcase
    return c;
  endfunction

  function automatic logic [vaor_pkg::STEP_W-1:0] dispatch(
    input logic [vaor_pkg::CMD_W-1:0] cmd
  );
    logic [vaor_pkg::STEP_W-1:0] s;
    unique case (cmd)
      vaor_pkg::CMD_ALLOC:      s = vaor_pkg::S_AL0;
      vaor_pkg::CMD_REL_OLDEST: s = vaor_pkg::S_RO0;
      vaor_pkg::CMD_REL_VOICE:  s = vaor_pkg::S_RV0;
      vaor_pkg::CMD_KEY_ON:     s = vaor_pkg::S_KEY;
      vaor_pkg::CMD_KEY_OFF:    s = vaor_pkg::S_KEY;
      default:                  s = vaor_pkg::S_ERR;
    endcase
    return s;
  endfunction

  assign cw     = ucode(pc_q);
  assign ctrl_o = cw;
  assign idle_o = (pc_q == vaor_pkg::S_IDLE);

  always_comb begin
    unique case (cw.cond)
      vaor_pkg::C_FREE_EMPTY: cond = stat_i.free_empty;
      vaor_pkg::C_BUSY_EMPTY: cond = stat_i.busy_empty;
      vaor_pkg::C_NOT_OCC:    cond = stat_i.not_occ;
      vaor_pkg::C_REL_VOICE:  cond = stat_i.rel_voice;
      vaor_pkg::C_V_BAD:      cond = stat_i.v_bad;
      vaor_pkg::C_OUT_FREE:   cond = stat_i.out_free;
      default:                cond = 1'b0;
    endcase
  end

  always_comb begin
    unique case (cw.jmp)
      vaor_pkg::J_NEXT: pc_d = pc_q + 1'b1;
      vaor_pkg::J_GOTO: pc_d = cw.target;
      vaor_pkg::J_IF:   pc_d = cond ? cw.target : pc_q + 1'b1;
      vaor_pkg::J_WAIT: pc_d = cond ? cw.target : pc_q;
      vaor_pkg::J_WALK: begin
        // list exhausted wins over a match on the current voice
        if (stat_i.walk_done) begin
          pc_d = cw.target;
        end else if (stat_i.walk_match) begin
          pc_d = pc_q + 1'b1;
        end else begin
          pc_d = pc_q;
        end
      end
      vaor_pkg::J_DISPATCH: pc_d = accept_i ? dispatch(command_i) : pc_q;
      default:              pc_d = vaor_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= vaor_pkg::S_IDLE;
    end else begin
      pc_q <= pc_d;
    end
  end

endmodule

@@ sv/vaor_dp.sv @@
// ----------------------------------------------------------------------------
// vaor_dp
// Datapath: shared link store for the free and occupied lists, key and
// occupied flags, list heads, tails and count, walk registers and the
// result register. Actions are selected by the sequencer's control word.
// ----------------------------------------------------------------------------
module vaor_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  vaor_pkg::ctrl_t               ctrl_i,
  input  logic                          accept_i,
  input  logic [vaor_pkg::CMD_W-1:0]    command_i,
  input  logic [vaor_pkg::VOICE_W-1:0]  voice_i,
  input  logic                          res_ready_i,
  output vaor_pkg::stat_t               stat_o,
  output logic                          res_valid_o,
  output logic [vaor_pkg::VOICE_W-1:0]  voice_out_o,
  output logic                          error_o,
  output logic                          free_avail_o
);

  // link store with per-entry written bits; unwritten entries read as reset chain
  logic [vaor_pkg::VW-1:0]     link_mem [vaor_pkg::VOICES];
  logic [vaor_pkg::VOICES-1:0] link_wr_q, link_wr_d;
  logic [vaor_pkg::VW-1:0]     rd_q;
  logic                        rd_en;
  logic [vaor_pkg::VW-1:0]     rd_addr;
  logic                        wr_en;
  logic [vaor_pkg::VW-1:0]     wr_addr, wr_data;

  logic [vaor_pkg::VOICES-1:0] key_q, key_d, occ_q, occ_d;
  logic [vaor_pkg::VW-1:0]     free_head_q, free_head_d, free_tail_q, free_tail_d;
  logic [vaor_pkg::VW-1:0]     busy_head_q, busy_head_d, busy_tail_q, busy_tail_d;
  logic [vaor_pkg::CW-1:0]     free_cnt_q, free_cnt_d;

  logic [vaor_pkg::CMD_W-1:0]   cmd_q, cmd_d;
  logic [vaor_pkg::VOICE_W-1:0] v_q, v_d;
  logic [vaor_pkg::VW-1:0]      cur_q, cur_d, prev_q, prev_d;
  logic                         has_prev_q, has_prev_d;
  logic [vaor_pkg::CW-1:0]      k_q, k_d;
  logic [vaor_pkg::VOICE_W-1:0] vo_q, vo_d;
  logic                         err_q, err_d;

  logic                         out_valid_q, out_valid_d;
  logic [vaor_pkg::VOICE_W-1:0] out_voice_q, out_voice_d;
  logic                         out_err_q, out_err_d;
  logic                         out_free_q, out_free_d;

  logic                         free_empty, busy_empty, out_free, out_load;
  logic [vaor_pkg::CW-1:0]      busy_n;
  logic                         v_ok, walk_done, walk_match, advance;
  logic [vaor_pkg::VW-1:0]      v_idx;

  function automatic logic [vaor_pkg::VW-1:0] init_link(input logic [vaor_pkg::VW-1:0] i);
    return (int'(i) + 1 < vaor_pkg::VOICES) ? vaor_pkg::VW'(int'(i) + 1) : '0;
  endfunction

  assign free_empty = (free_cnt_q == '0);
  assign busy_empty = (free_cnt_q == vaor_pkg::CW'(vaor_pkg::VOICES));
  assign busy_n     = vaor_pkg::CW'(vaor_pkg::VOICES) - free_cnt_q;
  assign v_ok       = (int'(v_q) < vaor_pkg::VOICES);
  assign v_idx      = vaor_pkg::VW'(v_q);
  assign walk_done  = (k_q >= busy_n);
  assign walk_match = (cmd_q == vaor_pkg::CMD_REL_VOICE) ? (cur_q == v_idx)
                                                         : !key_q[cur_q];
  assign advance    = !walk_done && !walk_match;
  assign out_free   = !out_valid_q || res_ready_i;
  assign out_load   = (ctrl_i.act == vaor_pkg::A_FINISH) && out_free;

  assign stat_o.free_empty = free_empty;
  assign stat_o.busy_empty = busy_empty;
  assign stat_o.not_occ    = !v_ok || !occ_q[v_idx];
  assign stat_o.rel_voice  = (cmd_q == vaor_pkg::CMD_REL_VOICE);
  assign stat_o.v_bad      = !v_ok;
  assign stat_o.out_free   = out_free;
  assign stat_o.walk_done  = walk_done;
  assign stat_o.walk_match = walk_match;

  // read port
  always_comb begin
    unique case (ctrl_i.rsel)
      vaor_pkg::R_FREE_HEAD: rd_addr = free_head_q;
      vaor_pkg::R_BUSY_HEAD: rd_addr = busy_head_q;
      vaor_pkg::R_RD:        rd_addr = rd_q;
      default:               rd_addr = '0;
    endcase
    // during the walk the link of the current voice is held once it matches
    rd_en = (ctrl_i.rsel != vaor_pkg::R_NONE) &&
            ((ctrl_i.act != vaor_pkg::A_WALK) || advance);
  end

  always_comb begin
    free_head_d = free_head_q;
    free_tail_d = free_tail_q;
    busy_head_d = busy_head_q;
    busy_tail_d = busy_tail_q;
    free_cnt_d  = free_cnt_q;
    key_d       = key_q;
    occ_d       = occ_q;
    cmd_d       = cmd_q;
    v_d         = v_q;
    cur_d       = cur_q;
    prev_d      = prev_q;
    has_prev_d  = has_prev_q;
    k_d         = k_q;
    vo_d        = vo_q;
    err_d       = err_q;
    wr_en       = 1'b0;
    wr_addr     = '0;
    wr_data     = '0;

    unique case (ctrl_i.act)
      vaor_pkg::A_LATCH: begin
        if (accept_i) begin
          cmd_d = command_i;
          v_d   = voice_i;
          err_d = 1'b0;
          if (command_i == vaor_pkg::CMD_REL_VOICE || command_i == vaor_pkg::CMD_KEY_ON ||
              command_i == vaor_pkg::CMD_KEY_OFF) begin
            vo_d = voice_i;
          end else begin
            vo_d = '0;
          end
        end
      end
      vaor_pkg::A_ALLOC: begin
        free_head_d = rd_q;
        free_cnt_d  = free_cnt_q - 1'b1;
        if (busy_empty) begin
          busy_head_d = free_head_q;
        end else begin
          wr_en   = 1'b1;
          wr_addr = busy_tail_q;
          wr_data = free_head_q;
        end
        busy_tail_d         = free_head_q;
        occ_d[free_head_q]  = 1'b1;
        vo_d                = vaor_pkg::VOICE_W'(free_head_q);
      end
      vaor_pkg::A_WALK_INIT: begin
        cur_d      = busy_head_q;
        prev_d     = '0;
        has_prev_d = 1'b0;
        k_d        = '0;
      end
      vaor_pkg::A_WALK: begin
        if (advance) begin
          prev_d     = cur_q;
          has_prev_d = 1'b1;
          cur_d      = rd_q;
          k_d        = k_q + 1'b1;
        end
      end
      vaor_pkg::A_PICK_HEAD: begin
        cur_d      = busy_head_q;
        prev_d     = '0;
        has_prev_d = 1'b0;
      end
      vaor_pkg::A_UNLINK: begin
        // rd_q holds the link out of the picked voice
        if (cur_q == busy_head_q) begin
          busy_head_d = rd_q;
        end
        if (cur_q == busy_tail_q) begin
          busy_tail_d = has_prev_q ? prev_q : '0;
        end
        if (has_prev_q) begin
          wr_en   = 1'b1;
          wr_addr = prev_q;
          wr_data = rd_q;
        end
        occ_d[cur_q] = 1'b0;
        key_d[cur_q] = 1'b0;
      end
      vaor_pkg::A_APPEND: begin
        if (free_empty) begin
          free_head_d = cur_q;
        end else begin
          wr_en   = 1'b1;
          wr_addr = free_tail_q;
          wr_data = cur_q;
        end
        free_tail_d = cur_q;
        free_cnt_d  = free_cnt_q + 1'b1;
        vo_d        = vaor_pkg::VOICE_W'(cur_q);
      end
      vaor_pkg::A_KEY: begin
        if (v_ok) begin
          key_d[v_idx] = (cmd_q == vaor_pkg::CMD_KEY_ON);
        end
      end
      vaor_pkg::A_ERR: begin
        err_d = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    link_wr_d = link_wr_q;
    if (wr_en) begin
      link_wr_d[wr_addr] = 1'b1;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_voice_d = out_voice_q;
    out_err_d   = out_err_q;
    out_free_d  = out_free_q;
    if (out_load) begin
      out_valid_d = 1'b1;
      out_voice_d = vo_q;
      out_err_d   = err_q;
      out_free_d  = !free_empty;
    end else if (res_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      link_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= link_wr_q[rd_addr] ? link_mem[rd_addr] : init_link(rd_addr);
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_d_reg: begin
      cmd_q       <= cmd_d;
      v_q         <= v_d;
      cur_q       <= cur_d;
      prev_q      <= prev_d;
      has_prev_q  <= has_prev_d;
      k_q         <= k_d;
      vo_q        <= vo_d;
      err_q       <= err_d;
      out_voice_q <= out_voice_d;
      out_err_q   <= out_err_d;
      out_free_q  <= out_free_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      link_wr_q   <= '0;
      key_q       <= '0;
      occ_q       <= '0;
      free_head_q <= '0;
      free_tail_q <= vaor_pkg::VW'(vaor_pkg::VOICES - 1);
      free_cnt_q  <= vaor_pkg::CW'(vaor_pkg::VOICES);
      busy_head_q <= '0;
      busy_tail_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      link_wr_q   <= link_wr_d;
      key_q       <= key_d;
      occ_q       <= occ_d;
      free_head_q <= free_head_d;
      free_tail_q <= free_tail_d;
      free_cnt_q  <= free_cnt_d;
      busy_head_q <= busy_head_d;
      busy_tail_q <= busy_tail_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign res_valid_o  = out_valid_q;
  assign voice_out_o  = out_voice_q;
  assign error_o      = out_err_q;
  assign free_avail_o = out_free_q;

endmodule

@@ sv/voice_allocator_oldest_release_top.sv @@
// ----------------------------------------------------------------------------
// voice_allocator_oldest_release_top
// Synth voice allocator: free and occupied age-ordered lists, oldest key-off
// release with oldest-voice steal, named release and key on/off.
// ----------------------------------------------------------------------------
// One request is worked at a time by a microprogram of thirteen steps; the
// request channel is ready only while the sequencer sits in its idle step, and
// a finished result waits in an output register so the next request can be
// taken before it is collected. Both release commands walk the occupied list
// one voice per cycle through the link store's single read port; with every
// key held, release oldest steals the oldest occupied voice. A request also
// waits in its last step for as long as the previous result still sits
// uncollected in the output register.
module voice_allocator_oldest_release_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  vaor_cmd_if.sink    cmd_i,
  vaor_res_if.source  res_o
);

  vaor_pkg::ctrl_t ctrl;
  vaor_pkg::stat_t stat;
  logic            idle;
  logic            accept;

  assign cmd_i.ready = idle;
  assign accept      = cmd_i.valid && idle;

  vaor_seq u_seq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .command_i (cmd_i.command),
    .stat_i    (stat),
    .ctrl_o    (ctrl),
    .idle_o    (idle)
  );

  vaor_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (ctrl),
    .accept_i     (accept),
    .command_i    (cmd_i.command),
    .voice_i      (cmd_i.voice),
    .res_ready_i  (res_o.ready),
    .stat_o       (stat),
    .res_valid_o  (res_o.valid),
    .voice_out_o  (res_o.voice_out),
    .error_o      (res_o.error),
    .free_avail_o (res_o.free_available)
  );

endmodule
